[hdl/rotated_packed_pixel_store_macros.svh]
// assertion macros for the rotated packed pixel store
`ifndef ROTATED_PACKED_PIXEL_STORE_MACROS_SVH
`define ROTATED_PACKED_PIXEL_STORE_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define RPPS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rpps assertion failed");

// next-cycle implication
`define RPPS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rpps assertion failed");

`else

`define RPPS_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define RPPS_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

[hdl/rpps_pkg.sv]
// shared types and constants of the rotated packed pixel store
package rpps_pkg;

    localparam int STORE_BYTES = 65536;   // power of two, byte addresses wrap
    localparam int ADDR_BITS   = $clog2(STORE_BYTES);
    localparam int COORD_BITS  = 12;
    localparam int DIM_BITS    = 13;
    localparam int COLOR_BITS  = 24;
    localparam int MAP_BITS    = (DIM_BITS > COORD_BITS) ? DIM_BITS : COORD_BITS;
    localparam int SGN_BITS    = MAP_BITS + 2;
    localparam int IDX_BITS    = MAP_BITS + DIM_BITS + 1;
    localparam int WORK_BITS   = (IDX_BITS > ADDR_BITS + 3) ? IDX_BITS : ADDR_BITS + 3;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [7:0] MIRROR_Y_SET = 8'b10010110;
    localparam logic [7:0] BYTE_MASK    = 8'hFF;

    // configuration register indexes
    localparam int CFG_IDX_BITS = 3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ORIENTATION  = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DEPTH_CODE   = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_PANEL_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_PANEL_HEIGHT = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ROW_PITCH    = 3'd4;

    // depth codes
    localparam logic [2:0] DEPTH_1  = 3'd0;
    localparam logic [2:0] DEPTH_2  = 3'd1;
    localparam logic [2:0] DEPTH_4  = 3'd2;
    localparam logic [2:0] DEPTH_8  = 3'd3;
    localparam logic [2:0] DEPTH_16 = 3'd4;

    // register reset values
    localparam logic [2:0]          RST_ORIENTATION = 3'd0;
    localparam logic [2:0]          RST_DEPTH_CODE  = DEPTH_16;
    localparam logic [DIM_BITS-1:0] RST_WIDTH       = 13'd320;
    localparam logic [DIM_BITS-1:0] RST_HEIGHT      = 13'd240;
    localparam logic [DIM_BITS-1:0] RST_PITCH       = 13'd320;

    typedef struct packed {
        logic [2:0]          orientation;
        logic [2:0]          depth_code;
        logic [DIM_BITS-1:0] panel_width;
        logic [DIM_BITS-1:0] panel_height;
        logic [DIM_BITS-1:0] row_pitch;
    } t_cfg;

    typedef struct packed {
        logic                  action;
        logic [COORD_BITS-1:0] pos_x;
        logic [COORD_BITS-1:0] pos_y;
        logic [COLOR_BITS-1:0] raw_color;
    } t_item;

    typedef struct packed {
        logic [COLOR_BITS-1:0] pixel_value;
        logic                  outside_panel;
    } t_result;

    // one classified access between front and back
    typedef struct packed {
        logic                  is_read;
        logic                  outside;
        logic                  packed_px;
        logic [1:0]            last;      // bytes minus one
        logic [ADDR_BITS-1:0]  addr;
        logic [7:0]            pmask;
        logic [2:0]            shift;
        logic [7:0]            vmask;
        logic [COLOR_BITS-1:0] color;
    } t_cmd;

endpackage

[hdl/rotated_packed_pixel_store.sv]
// top level of the rotated packed pixel store: config registers and wiring
//  - input side is a queue: drive i_item and raise push; the transfer
//    happens on a clock edge with push high and full low
//  - result side is a holding register: o_result holds the oldest result while empty
//    is low; pop high on such an edge takes it
//  - only reads give a result; writes, including dropped ones outside the
//    panel, give none
//  - config: i_cfg_valid with i_cfg_index / i_cfg_data, always ready;
//    write only while the block is idle
//  - a front end maps and clips in two registered stages and queues the
//    access; the memory sequencer behind the queue then takes one item
//    at a time: a write stores its bytes in turn, a read fetches them in
//    turn and merges them in a finish state, a packed read picks its
//    field from the byte, a packed write reads the byte and writes it
//    back masked, and a read outside the panel goes straight to emit;
//    it makes one frame memory byte access a cycle while reading or writing
//  - reset (i_rst_n low, synchronous) empties the pipeline and loads the
//    register defaults; frame contents are undefined until written
//  - a stalled result side holds the sequencer on its finished read; the
//    queue and front stages keep taking items until they fill
module rotated_packed_pixel_store (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  push,
    input  rpps_pkg::t_item                       i_item,
    output logic                                  full,
    output logic                                  empty,
    input  logic                                  pop,
    output rpps_pkg::t_result                     o_result,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [rpps_pkg::CFG_IDX_BITS-1:0]     i_cfg_index,
    input  logic [rpps_pkg::DIM_BITS-1:0]         i_cfg_data
);

    rpps_pkg::t_cfg r_cfg;
    logic           cfg_we;

    // front to queue
    logic           q_push, q_full;
    rpps_pkg::t_cmd q_in_cmd;
    // queue to back
    logic           q_pop, q_empty;
    rpps_pkg::t_cmd q_out_cmd;

    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;

    // register file, values masked to their widths, unknown indexes ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.orientation  <= rpps_pkg::RST_ORIENTATION;
            r_cfg.depth_code   <= rpps_pkg::RST_DEPTH_CODE;
            r_cfg.panel_width  <= rpps_pkg::RST_WIDTH;
            r_cfg.panel_height <= rpps_pkg::RST_HEIGHT;
            r_cfg.row_pitch    <= rpps_pkg::RST_PITCH;
        end else if (cfg_we) begin
            case (i_cfg_index)
                rpps_pkg::CFG_ORIENTATION:  r_cfg.orientation  <= i_cfg_data[2:0];
                rpps_pkg::CFG_DEPTH_CODE:   r_cfg.depth_code   <= i_cfg_data[2:0];
                rpps_pkg::CFG_PANEL_WIDTH:  r_cfg.panel_width  <= i_cfg_data;
                rpps_pkg::CFG_PANEL_HEIGHT: r_cfg.panel_height <= i_cfg_data;
                rpps_pkg::CFG_ROW_PITCH:    r_cfg.row_pitch    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // mapping, clipping and address generation
    rpps_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .push     (push),
        .i_item   (i_item),
        .full     (full),
        .o_q_push (q_push),
        .o_q_cmd  (q_in_cmd),
        .i_q_full (q_full)
    );

    // decouples the front stages from the memory sequencer
    rpps_cmd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_in_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_cmd   (q_out_cmd),
        .o_empty (q_empty)
    );

    // frame memory and byte sequencing
    rpps_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_q_cmd   (q_out_cmd),
        .o_q_pop   (q_pop),
        .empty     (empty),
        .pop       (pop),
        .o_result  (o_result)
    );

endmodule

[hdl/rpps_front.sv]
// front end: orientation mapping, clipping, index and byte address
module rpps_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  rpps_pkg::t_cfg i_cfg,
    input  logic           push,
    input  rpps_pkg::t_item i_item,
    output logic           full,
    output logic           o_q_push,
    output rpps_pkg::t_cmd o_q_cmd,
    input  logic           i_q_full
);

    localparam int SW = rpps_pkg::SGN_BITS;
    localparam int MW = rpps_pkg::MAP_BITS;
    localparam int WW = rpps_pkg::WORK_BITS;
    localparam int AW = rpps_pkg::ADDR_BITS;
    localparam int CW = rpps_pkg::COLOR_BITS;

    // stage 1: mapped coordinates
    logic          r_s1_v;
    logic [MW-1:0] r_s1_x, r_s1_y;
    logic          r_s1_out, r_s1_rd;
    logic [CW-1:0] r_s1_color;

    // stage 2: pixel index
    logic          r_s2_v;
    logic [WW-1:0] r_s2_idx;
    logic          r_s2_out, r_s2_rd;
    logic [CW-1:0] r_s2_color;

    logic          push_need, s1_ready, s2_ready, accept;
    logic [rpps_pkg::DIM_BITS-1:0] lw, lh;
    logic [SW-1:0] xs, ys, x1, y1, xm, ym;
    logic          outside;

    assign push_need = r_s2_v && (r_s2_rd || !r_s2_out);
    assign s2_ready  = !r_s2_v || !push_need || !i_q_full;
    assign s1_ready  = !r_s1_v || s2_ready;
    assign full      = !s1_ready;
    assign accept    = push && s1_ready;
    assign o_q_push  = push_need && !i_q_full;

    always_comb begin
        lw = i_cfg.orientation[0] ? i_cfg.panel_height : i_cfg.panel_width;
        lh = i_cfg.orientation[0] ? i_cfg.panel_width  : i_cfg.panel_height;
        xs = SW'(i_item.pos_x);
        ys = SW'(i_item.pos_y);
        y1 = rpps_pkg::MIRROR_Y_SET[i_cfg.orientation] ? SW'(lh) - ys - SW'(1) : ys;
        x1 = i_cfg.orientation[1] ? SW'(lw) - xs - SW'(1) : xs;
        xm = i_cfg.orientation[0] ? y1 : x1;
        ym = i_cfg.orientation[0] ? x1 : y1;
        outside = xm[SW-1] || ym[SW-1] ||
                  (xm >= SW'(i_cfg.panel_width)) || (ym >= SW'(i_cfg.panel_height));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
        end else begin
            if (s1_ready) begin
                r_s1_v <= accept;
            end
            if (s2_ready) begin
                r_s2_v <= r_s1_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_x     <= xm[MW-1:0];
            r_s1_y     <= ym[MW-1:0];
            r_s1_out   <= outside;
            r_s1_rd    <= i_item.action;
            r_s1_color <= i_item.raw_color;
        end
        if (s2_ready && r_s1_v) begin
            r_s2_idx   <= WW'(r_s1_x) + WW'(r_s1_y) * WW'(i_cfg.row_pitch);
            r_s2_out   <= r_s1_out;
            r_s2_rd    <= r_s1_rd;
            r_s2_color <= r_s1_color;
        end
    end

    // byte address and masks from the index
    logic [WW-1:0] bitpos, base;
    logic [1:0]    dlog;
    logic [3:0]    bits;
    logic [2:0]    off;
    logic [7:0]    top, vmask;

    always_comb begin
        o_q_cmd           = '0;
        o_q_cmd.is_read   = r_s2_rd;
        o_q_cmd.outside   = r_s2_out;
        o_q_cmd.color     = r_s2_color;
        dlog              = 2'd0;
        top               = 8'h80;
        vmask             = 8'h01;
        case (i_cfg.depth_code)
            rpps_pkg::DEPTH_1: begin
                dlog = 2'd0; top = 8'h80; vmask = 8'h01;
            end
            rpps_pkg::DEPTH_2: begin
                dlog = 2'd1; top = 8'hC0; vmask = 8'h03;
            end
            rpps_pkg::DEPTH_4: begin
                dlog = 2'd2; top = rpps_pkg::BYTE_MASK & 8'hF0; vmask = 8'h0F;
            end
            default: begin
                dlog = 2'd0; top = 8'h80; vmask = 8'h01;
            end
        endcase
        bits   = 4'd1 << dlog;
        bitpos = r_s2_idx << dlog;
        off    = bitpos[2:0];
        base   = r_s2_idx;
        case (i_cfg.depth_code)
            rpps_pkg::DEPTH_1, rpps_pkg::DEPTH_2, rpps_pkg::DEPTH_4: begin
                o_q_cmd.packed_px = 1'b1;
                o_q_cmd.last      = 2'd0;
                o_q_cmd.addr      = bitpos[AW+2:3];
                o_q_cmd.pmask     = top >> off;
                o_q_cmd.shift     = 3'(4'd8 - {1'b0, off} - bits);
                o_q_cmd.vmask     = vmask;
            end
            rpps_pkg::DEPTH_8: begin
                o_q_cmd.last = 2'd0;
                o_q_cmd.addr = base[AW-1:0];
            end
            rpps_pkg::DEPTH_16: begin
                o_q_cmd.last = 2'd1;
                base         = r_s2_idx << 1;
                o_q_cmd.addr = base[AW-1:0];
            end
            default: begin
                // 24 bits, also for the unused codes
                o_q_cmd.last = 2'd2;
                base         = r_s2_idx + (r_s2_idx << 1);
                o_q_cmd.addr = base[AW-1:0];
            end
        endcase
    end

endmodule

[hdl/rpps_cmd_queue.sv]
// short command queue between front end and memory sequencer
module rpps_cmd_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  rpps_pkg::t_cmd i_cmd,
    output logic           o_full,
    input  logic           i_pop,
    output rpps_pkg::t_cmd o_cmd,
    output logic           o_empty
);

    localparam int PW = $clog2(rpps_pkg::QUEUE_DEPTH);
    localparam int NW = $clog2(rpps_pkg::QUEUE_DEPTH + 1);

    rpps_pkg::t_cmd r_q [rpps_pkg::QUEUE_DEPTH];
    logic [PW-1:0]  r_wr, r_rd;
    logic [NW-1:0]  r_cnt;
    logic           do_push, do_pop;

    assign o_full  = (r_cnt == NW'(rpps_pkg::QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_cmd   = r_q[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PW'(rpps_pkg::QUEUE_DEPTH - 1)) ? '0 : r_wr + PW'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == PW'(rpps_pkg::QUEUE_DEPTH - 1)) ? '0 : r_rd + PW'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + NW'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - NW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_q[r_wr] <= i_cmd;
        end
    end

endmodule

[hdl/rpps_back.sv]
// back end: frame memory, byte sequencer and result register
`include "rotated_packed_pixel_store_macros.svh"

module rpps_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_empty,
    input  rpps_pkg::t_cmd  i_q_cmd,
    output logic            o_q_pop,
    output logic            empty,
    input  logic            pop,
    output rpps_pkg::t_result o_result
);

    localparam int AW = rpps_pkg::ADDR_BITS;
    localparam int CW = rpps_pkg::COLOR_BITS;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_WRITE  = 3'd1;
    localparam logic [2:0] S_READ   = 3'd2;
    localparam logic [2:0] S_FINISH = 3'd3;
    localparam logic [2:0] S_EMIT   = 3'd4;

    logic [7:0]     r_mem [rpps_pkg::STORE_BYTES];
    logic [7:0]     r_rd_data;

    logic [2:0]     r_state, n_state;
    rpps_pkg::t_cmd r_cmd;
    logic [1:0]     r_cnt, n_cnt;
    logic           r_pend, n_pend;
    logic [1:0]     r_pend_lane;
    logic [CW-1:0]  r_acc, acc_merge;
    logic [CW-1:0]  r_val, n_val;
    logic           r_flag, n_flag;
    logic           r_out_valid;
    rpps_pkg::t_result r_out;

    logic           rd_en, wr_en, out_load, load_cmd;
    logic [AW-1:0]  rd_addr, wr_addr, lane_addr;
    logic [7:0]     wr_data, color_byte;

    assign empty     = !r_out_valid;
    assign o_result  = r_out;
    assign lane_addr = r_cmd.addr + AW'(r_cnt);

    always_comb begin
        case (r_pend_lane)
            2'd0:    acc_merge = r_acc | {16'd0, r_rd_data};
            2'd1:    acc_merge = r_acc | {8'd0, r_rd_data, 8'd0};
            default: acc_merge = r_acc | {r_rd_data, 16'd0};
        endcase
        if (!r_pend) begin
            acc_merge = r_acc;
        end
        case (r_cnt)
            2'd0:    color_byte = r_cmd.color[7:0];
            2'd1:    color_byte = r_cmd.color[15:8];
            default: color_byte = r_cmd.color[23:16];
        endcase
    end

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_pend   = 1'b0;
        n_val    = r_val;
        n_flag   = r_flag;
        o_q_pop  = 1'b0;
        load_cmd = 1'b0;
        rd_en    = 1'b0;
        rd_addr  = lane_addr;
        wr_en    = 1'b0;
        wr_addr  = lane_addr;
        wr_data  = color_byte;
        out_load = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (!i_q_empty) begin
                    o_q_pop  = 1'b1;
                    load_cmd = 1'b1;
                    n_cnt    = 2'd0;
                    if (i_q_cmd.outside) begin
                        n_val   = '0;
                        n_flag  = 1'b1;
                        n_state = S_EMIT;
                    end else if (i_q_cmd.packed_px || i_q_cmd.is_read) begin
                        n_state = S_READ;
                    end else begin
                        n_state = S_WRITE;
                    end
                end
            end
            S_WRITE: begin
                wr_en = 1'b1;
                if (r_cnt == r_cmd.last) begin
                    n_state = S_IDLE;
                end else begin
                    n_cnt = r_cnt + 2'd1;
                end
            end
            S_READ: begin
                rd_en  = 1'b1;
                n_pend = 1'b1;
                if (r_cnt == r_cmd.last) begin
                    n_state = S_FINISH;
                end else begin
                    n_cnt = r_cnt + 2'd1;
                end
            end
            S_FINISH: begin
                if (r_cmd.packed_px && !r_cmd.is_read) begin
                    // masked merge into the byte just read
                    wr_en   = 1'b1;
                    wr_addr = r_cmd.addr;
                    wr_data = (r_rd_data & ~r_cmd.pmask) | (r_cmd.color[7:0] & r_cmd.pmask);
                    n_state = S_IDLE;
                end else if (r_cmd.packed_px) begin
                    n_val   = CW'((r_rd_data >> r_cmd.shift) & r_cmd.vmask);
                    n_flag  = 1'b0;
                    n_state = S_EMIT;
                end else begin
                    n_val   = acc_merge;
                    n_flag  = 1'b0;
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (!r_out_valid || pop) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pend  <= n_pend;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt       <= n_cnt;
        r_val       <= n_val;
        r_flag      <= n_flag;
        r_pend_lane <= r_cnt;
        if (load_cmd) begin
            r_cmd <= i_q_cmd;
            r_acc <= '0;
        end else begin
            r_acc <= acc_merge;
        end
        if (out_load) begin
            r_out.pixel_value   <= r_val;
            r_out.outside_panel <= r_flag;
        end
    end

    // frame memory, one write and one registered read a cycle
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    `RPPS_ASSERT_IMP(a_no_write_idle, i_clk, i_rst_n, r_state == S_IDLE, !wr_en)
    `RPPS_ASSERT_IMP(a_out_slot_free, i_clk, i_rst_n, out_load, !r_out_valid || pop)
    `RPPS_ASSERT_NXT(a_last_read_lands, i_clk, i_rst_n, rd_en && r_cnt == r_cmd.last, r_pend && r_state == S_FINISH)

endmodule
